@@ rtl/dpsd_pkg.sv @@
package dpsd_pkg;

    localparam int SYMBOLS_PER_BLOCK = 28;

    localparam int POS_W = 5;
    localparam int SYM_W = 2;
    localparam int IDX_W = 5;
    localparam int DIFF_W = 18;   // d stays within 3125..196875

    localparam int DIFF_STEP = 3125;
    localparam int DIFF_OFFSET = 100000;

    localparam logic [IDX_W-1:0] SYNC_RESET = IDX_W'(3);
    localparam logic [SYM_W-1:0] SYM_ZERO = '0;

    typedef struct packed {
        logic [DIFF_W-1:0] lo;
        logic [DIFF_W-1:0] hi;
        logic [SYM_W-1:0]  sym;
    } window_t;

    typedef struct packed {
        logic             hit;
        logic [SYM_W-1:0] sym;
    } decision_t;

    function automatic window_t mk_win(input int lo, input int hi, input int sym);
        window_t w;
        w.lo  = DIFF_W'(lo);
        w.hi  = DIFF_W'(hi);
        w.sym = SYM_W'(sym);
        return w;
    endfunction

    // Windows per table, in priority order.
    function automatic window_t win_get(input logic [SYM_W-1:0] tbl, input logic [1:0] k);
        window_t w;
        w = mk_win(0, 0, 0);
        unique case ({tbl, k})
            4'h0: w = mk_win( 85000, 110000, 0);
            4'h1: w = mk_win(165000, 185000, 2);
            4'h2: w = mk_win(140000, 160000, 3);
            4'h3: w = mk_win(115000, 135000, 1);
            4'h4: w = mk_win( 65000,  85000, 0);
            4'h5: w = mk_win(140000, 160000, 2);
            4'h6: w = mk_win(115000, 135000, 3);
            4'h7: w = mk_win( 85000, 110000, 1);
            4'h8: w = mk_win( 15000,  35000, 0);
            4'h9: w = mk_win( 85000, 110000, 2);
            4'ha: w = mk_win( 65000,  80000, 3);
            4'hb: w = mk_win( 40000,  60000, 1);
            4'hc: w = mk_win( 40000,  60000, 0);
            4'hd: w = mk_win(140000, 160000, 2);
            4'he: w = mk_win(115000, 135000, 3);
            4'hf: w = mk_win( 85000, 110000, 1);
            default: w = mk_win(0, 0, 0);
        endcase
        return w;
    endfunction

endpackage

@@ rtl/dpsd_classify.sv @@
module dpsd_classify
    import dpsd_pkg::*;
(
    input  logic [POS_W-1:0] peak_pos,
    input  logic [POS_W-1:0] prev_pos,
    input  logic [SYM_W-1:0] last_sym,
    input  logic [IDX_W-1:0] sym_idx,
    input  logic [IDX_W-1:0] sync_symbols,
    output decision_t        decision
);

    logic signed [POS_W:0]  delta;
    logic signed [DIFF_W:0] diff_s;
    logic [DIFF_W-1:0]      diff;
    logic                   use_sync;
    decision_t              sync_dec;
    decision_t              last_dec;
    window_t                w0;
    window_t                wl;

    assign delta  = $signed({1'b0, peak_pos}) - $signed({1'b0, prev_pos});
    assign diff_s = (DIFF_W+1)'(DIFF_OFFSET) + (DIFF_W+1)'(delta) * (DIFF_W+1)'(DIFF_STEP);
    assign diff   = diff_s[DIFF_W-1:0];

    assign use_sync = (sym_idx <= sync_symbols) || (last_sym == SYM_ZERO);

    // First hit in table order wins; walk backwards so earlier entries override.
    always_comb
    begin
        sync_dec = '0;
        last_dec = '0;
        for (int k = 3; k >= 0; k--)
        begin
            w0 = win_get(SYM_ZERO, 2'(k));
            wl = win_get(last_sym, 2'(k));
            if (diff >= w0.lo && diff <= w0.hi)
            begin
                sync_dec.hit = 1'b1;
                sync_dec.sym = w0.sym;
            end
            if (diff >= wl.lo && diff <= wl.hi)
            begin
                last_dec.hit = 1'b1;
                last_dec.sym = wl.sym;
            end
        end
    end

    always_comb
    begin
        if (use_sync && sync_dec.hit)
            decision = sync_dec;
        else if (last_sym != SYM_ZERO && last_dec.hit)
            decision = last_dec;
        else
        begin
            decision.hit = 1'b0;
            decision.sym = last_sym;  // miss repeats the last symbol
        end
    end

endmodule

@@ rtl/differential_phase_symbol_decoder.sv @@
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | peak_pos, block_start
// out     | output    | out_valid/out_stall| symbol, matched, symbol_index, last
// cfg     | input     | cfg_valid/cfg_ready| cfg_data (sync_symbols)
//
// One wave per cycle sustained while the output does not stall; an accepted request
// goes to the input register, then its result to the result register.
// The window match and state update sit between those registers.
// Reset clears position, last symbol, count and reference; sync_symbols goes to 3.
// A stalled result holds; the input stalls only when the staged request
// needs the result register and it is full and stalled.
module differential_phase_symbol_decoder
    import dpsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             in_valid,
    output logic             in_stall,
    input  logic [POS_W-1:0] peak_pos,
    input  logic             block_start,

    output logic             out_valid,
    input  logic             out_stall,
    output logic [SYM_W-1:0] symbol,
    output logic             matched,
    output logic [IDX_W-1:0] symbol_index,
    output logic             last,

    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_data
);

    // input register
    logic             s1_valid_reg;
    logic [POS_W-1:0] s1_pos_reg;
    logic             s1_start_reg;

    // decoder state
    logic [POS_W-1:0] prev_pos_reg;
    logic [SYM_W-1:0] last_sym_reg;
    logic [IDX_W-1:0] count_reg;
    logic             have_ref_reg;
    logic [IDX_W-1:0] sync_reg;

    // result register
    logic             out_valid_reg;
    logic [SYM_W-1:0] symbol_reg;
    logic             matched_reg;
    logic [IDX_W-1:0] index_reg;
    logic             last_reg;

    decision_t        decision;
    logic             is_ref;
    logic             out_free;
    logic             s1_go;
    logic             s1_fire;
    logic             out_load;
    logic             is_last;
    logic             in_take;
    logic [IDX_W-1:0] count_next;

    dpsd_classify u_classify (
        .peak_pos     (s1_pos_reg),
        .prev_pos     (prev_pos_reg),
        .last_sym     (last_sym_reg),
        .sym_idx      (count_reg),
        .sync_symbols (sync_reg),
        .decision     (decision)
    );

    assign is_ref   = s1_start_reg || !have_ref_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_go    = is_ref || out_free;
    assign s1_fire  = s1_valid_reg && s1_go;
    assign out_load = s1_fire && !is_ref;
    assign is_last  = ({1'b0, count_reg} + (IDX_W+1)'(1)) >= (IDX_W+1)'(SYMBOLS_PER_BLOCK);
    assign count_next = is_last ? '0 : count_reg + IDX_W'(1);

    assign in_stall = s1_valid_reg && !s1_go;
    assign in_take  = in_valid && !in_stall;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_pos_reg   <= peak_pos;
            s1_start_reg <= block_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pos_reg <= '0;
            last_sym_reg <= '0;
            count_reg    <= '0;
            have_ref_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            prev_pos_reg <= s1_pos_reg;
            if (is_ref)
            begin
                count_reg    <= '0;
                have_ref_reg <= 1'b1;
            end
            else
            begin
                last_sym_reg <= decision.sym;
                count_reg    <= count_next;
                have_ref_reg <= !is_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sync_reg <= SYNC_RESET;
        else if (cfg_valid && cfg_ready)
            sync_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            symbol_reg  <= decision.sym;
            matched_reg <= decision.hit;
            index_reg   <= count_reg;
            last_reg    <= is_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign symbol       = symbol_reg;
    assign matched      = matched_reg;
    assign symbol_index = index_reg;
    assign last         = last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < IDX_W'(SYMBOLS_PER_BLOCK))
        else $error("symbol count out of range");

    a_last_drops_ref: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && is_last) |=> !have_ref_reg)
        else $error("reference kept after final symbol");

    a_miss_keeps_sym: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !decision.hit) |=> (symbol_reg == $past(last_sym_reg)
                                         && last_sym_reg == $past(last_sym_reg)))
        else $error("miss changed the symbol");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with room available");

endmodule

@@ tb/differential_phase_symbol_decoder_tb.sv @@
`default_nettype none

module differential_phase_symbol_decoder_tb
    import dpsd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int DIRECTED_ROWS = 19;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             matched;
        logic [IDX_W-1:0] index;
        logic             last;
    } symbol_result_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             start;
        logic             known;
        logic [SYM_W-1:0] symbol;
        logic             matched;
        logic [IDX_W-1:0] index;
        logic             last;
    } wave_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [POS_W-1:0] peak_pos = '0;
    logic             block_start = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [SYM_W-1:0] symbol;
    logic             matched;
    logic [IDX_W-1:0] symbol_index;
    logic             last;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_data = '0;

    // decoder shadow state
    logic [IDX_W-1:0] sync_limit;
    logic [POS_W-1:0] ref_pos;
    logic [SYM_W-1:0] prior_symbol;
    logic [IDX_W-1:0] sym_count;
    logic             ref_held;

    symbol_result_t   pending_symbols[$];
    int               error_count = 0;
    int               quiet_cycles = 0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    logic [POS_W-1:0] sent_pos = '0;
    wave_row_t        directed_rows[DIRECTED_ROWS];

    differential_phase_symbol_decoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .peak_pos     (peak_pos),
        .block_start  (block_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .symbol       (symbol),
        .matched      (matched),
        .symbol_index (symbol_index),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    // {hit, symbol} for one window table, windows tried in priority order
    function automatic logic [2:0] search_windows(input logic [SYM_W-1:0] tbl, input int d);
        int lo[4];
        int hi[4];
        int sy[4];
        case (tbl)
            2'd0:
            begin
                lo = '{85000, 165000, 140000, 115000};
                hi = '{110000, 185000, 160000, 135000};
                sy = '{0, 2, 3, 1};
            end
            2'd1:
            begin
                lo = '{65000, 140000, 115000, 85000};
                hi = '{85000, 160000, 135000, 110000};
                sy = '{0, 2, 3, 1};
            end
            2'd2:
            begin
                lo = '{15000, 85000, 65000, 40000};
                hi = '{35000, 110000, 80000, 60000};
                sy = '{0, 2, 3, 1};
            end
            default:
            begin
                lo = '{40000, 140000, 115000, 85000};
                hi = '{60000, 160000, 135000, 110000};
                sy = '{0, 2, 3, 1};
            end
        endcase
        for (int k = 0; k < 4; k++)
        begin
            if (d >= lo[k] && d <= hi[k])
                return {1'b1, SYM_W'(sy[k])};
        end
        return 3'b000;
    endfunction

    // Advances the shadow state by one wave; returns 1 when a symbol comes out.
    function automatic bit decode_wave(input logic [POS_W-1:0] pos, input logic start,
                                       output symbol_result_t res);
        int         d;
        logic [2:0] found;
        res = '0;
        if (start || !ref_held)
        begin
            ref_pos = pos;
            sym_count = '0;
            ref_held = 1'b1;
            return 1'b0;
        end
        d = (int'(pos) - int'(ref_pos)) * DIFF_STEP + DIFF_OFFSET;
        found = 3'b000;
        if (sym_count <= sync_limit || prior_symbol == SYM_ZERO)
            found = search_windows(SYM_ZERO, d);
        if (!found[2] && prior_symbol != SYM_ZERO)
            found = search_windows(prior_symbol, d);
        if (found[2])
            prior_symbol = found[1:0];
        res.symbol = prior_symbol;
        res.matched = found[2];
        res.index = sym_count;
        res.last = (int'(sym_count) + 1 >= SYMBOLS_PER_BLOCK);
        ref_pos = pos;
        if (res.last)
        begin
            ref_held = 1'b0;
            sym_count = '0;
        end
        else
            sym_count = sym_count + 1'b1;
        return 1'b1;
    endfunction

    // Position whose difference to the previous one mostly lands in some window.
    function automatic logic [POS_W-1:0] pick_position(input logic [POS_W-1:0] prev);
        int delta;
        int p;
        case ($urandom_range(0, 9))
            0: delta = $urandom_range(21, 27);
            1: delta = $urandom_range(13, 19);
            2: delta = $urandom_range(5, 11);
            3: delta = $urandom_range(0, 7) - 4;
            4: delta = -int'($urandom_range(5, 6));
            5: delta = -int'($urandom_range(7, 11));
            6: delta = -int'($urandom_range(13, 19));
            7: delta = -int'($urandom_range(21, 27));
            8:
            begin
                case ($urandom_range(0, 4))
                    0: delta = -20;
                    1: delta = -12;
                    2: delta = 4;
                    3: delta = 12;
                    default: delta = 20;
                endcase
            end
            default: return POS_W'($urandom_range(0, 31));
        endcase
        p = int'(prev) + delta;
        if (p < 0 || p > 31)
            p = int'(prev) - delta;
        if (p < 0 || p > 31)
            p = $urandom_range(0, 31);
        return POS_W'(p);
    endfunction

    task automatic send_wave(input logic [POS_W-1:0] pos, input logic start,
                             input logic known, input symbol_result_t typed);
        symbol_result_t res;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        peak_pos <= pos;
        block_start <= start;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_pos = pos;
        if (decode_wave(pos, start, res))
            pending_symbols.push_back(known ? typed : res);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_symbols.size() != 0)
            @(posedge clk);
        // reference-only waves give nothing back but may still be in the pipe
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sync_limit(input logic [IDX_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sync_limit = value;
    endtask

    task automatic run_random_phase(input logic [IDX_W-1:0] limit, input int snd, input int rcv);
        logic start;
        logic [POS_W-1:0] pos;
        wait_drained();
        write_sync_limit(limit);
        send_idle_pct = snd;
        recv_stall_pct = rcv;
        for (int n = 0; n < ITEMS_PER_PHASE; n++)
        begin
            if (n == ITEMS_PER_PHASE / 3)
                wait_drained();
            start = ($urandom_range(0, 99) < 4);
            pos = pick_position(sent_pos);
            send_wave(pos, start, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        symbol_result_t got;
        symbol_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{symbol, matched, symbol_index, last};
            if (pending_symbols.size() == 0)
            begin
                $error("unexpected result: symbol=%0d matched=%0d symbol_index=%0d last=%0d",
                       got.symbol, got.matched, got.index, got.last);
                error_count++;
            end
            else
            begin
                want = pending_symbols.pop_front();
                if (got.symbol !== want.symbol)
                begin
                    $error("symbol: expected %0d, got %0d", want.symbol, got.symbol);
                    error_count++;
                end
                if (got.matched !== want.matched)
                begin
                    $error("matched: expected %0d, got %0d", want.matched, got.matched);
                    error_count++;
                end
                if (got.index !== want.index)
                begin
                    $error("symbol_index: expected %0d, got %0d", want.index, got.index);
                    error_count++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    error_count++;
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("differential_phase_symbol_decoder_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        directed_rows = '{
            // no reference yet: wave only sets it
            '{5'd0,  1'b0, 1'b0, 2'd0, 1'b0, 5'd0, 1'b0},
            '{5'd0,  1'b0, 1'b1, 2'd0, 1'b1, 5'd0, 1'b0},
            // largest and smallest differences fall in no window
            '{5'd31, 1'b0, 1'b1, 2'd0, 1'b0, 5'd1, 1'b0},
            '{5'd0,  1'b0, 1'b1, 2'd0, 1'b0, 5'd2, 1'b0},
            '{5'd8,  1'b0, 1'b1, 2'd1, 1'b1, 5'd3, 1'b0},
            '{5'd8,  1'b0, 1'b0, 2'd0, 1'b0, 5'd0, 1'b0},
            '{5'd31, 1'b0, 1'b0, 2'd0, 1'b0, 5'd0, 1'b0},
            // restart mid-block
            '{5'd10, 1'b1, 1'b0, 2'd0, 1'b0, 5'd0, 1'b0},
            '{5'd31, 1'b0, 1'b0, 2'd0, 1'b0, 5'd0, 1'b0},
            '{5'd6,  1'b0, 1'b0, 2'd0, 1'b0, 5'd0, 1'b0},
            '{5'd20, 1'b0, 1'b0, 2'd0, 1'b0, 5'd0, 1'b0},
            '{5'd5,  1'b0, 1'b0, 2'd0, 1'b0, 5'd0, 1'b0},
            '{5'd5,  1'b0, 1'b0, 2'd0, 1'b0, 5'd0, 1'b0},
            '{5'd12, 1'b0, 1'b0, 2'd0, 1'b0, 5'd0, 1'b0},
            '{5'd31, 1'b1, 1'b0, 2'd0, 1'b0, 5'd0, 1'b0},
            '{5'd0,  1'b0, 1'b0, 2'd0, 1'b0, 5'd0, 1'b0},
            '{5'd15, 1'b0, 1'b0, 2'd0, 1'b0, 5'd0, 1'b0},
            '{5'd3,  1'b0, 1'b0, 2'd0, 1'b0, 5'd0, 1'b0},
            '{5'd24, 1'b0, 1'b0, 2'd0, 1'b0, 5'd0, 1'b0}
        };
        sync_limit = SYNC_RESET;
        ref_pos = '0;
        prior_symbol = SYM_ZERO;
        sym_count = '0;
        ref_held = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_wave(directed_rows[i].pos, directed_rows[i].start, directed_rows[i].known,
                      '{directed_rows[i].symbol, directed_rows[i].matched,
                        directed_rows[i].index, directed_rows[i].last});

        run_random_phase(IDX_W'(27), 9, 45);
        run_random_phase(IDX_W'(0), 45, 9);
        run_random_phase(IDX_W'($urandom_range(1, 26)), 0, 0);

        in_valid <= 1'b0;
        while (pending_symbols.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (pending_symbols.size() != 0)
        begin
            $error("%0d expected result(s) never arrived", pending_symbols.size());
            error_count++;
        end
        if (error_count == 0)
            $display("differential_phase_symbol_decoder_tb: PASS");
        else
            $display("differential_phase_symbol_decoder_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/dpsd_pkg.sv
rtl/dpsd_classify.sv
rtl/differential_phase_symbol_decoder.sv
tb/differential_phase_symbol_decoder_tb.sv
